// File: src/serial_bank_switch_mapper_top_macros.svh
// Assertion macros for the serial bank switch mapper.
`ifndef SERIAL_BANK_SWITCH_MAPPER_TOP_MACROS_SVH
`define SERIAL_BANK_SWITCH_MAPPER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SBSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbsm assertion failed");
`define SBSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbsm assertion failed");
`else
`define SBSM_ASSERT_NOW(lbl, ante, cons)
`define SBSM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: src/sbsm_pkg.sv
// Shared types, codes and constants of the serial bank switch mapper.
package sbsm_pkg;

  localparam int unsigned CartRamDepth = 8192;
  localparam int unsigned RamAw        = $clog2(CartRamDepth);

  localparam logic [7:0] PrgBankCountReset = 8'd2;
  localparam logic [7:0] ChrBankCountReset = 8'd0;
  localparam logic [4:0] ControlReset      = 5'h1C;

  typedef enum logic [1:0] {
    OpCpuRead  = 2'd0,
    OpCpuWrite = 2'd1,
    OpPpuRead  = 2'd2,
    OpPpuWrite = 2'd3
  } op_e;

  // Serial load target, from address bits 14..13
  typedef enum logic [1:0] {
    TgtControl = 2'd0,
    TgtChrLow  = 2'd1,
    TgtChrHigh = 2'd2,
    TgtPrg     = 2'd3
  } tgt_e;

  // PRG banking modes, control bits 3..2
  typedef enum logic [1:0] {
    PrgSwitch32A   = 2'd0,
    PrgSwitch32B   = 2'd1,
    PrgFixFirst    = 2'd2,
    PrgFixLast     = 2'd3
  } prg_mode_e;

  typedef enum logic {
    CfgPrgBankCount = 1'b0,
    CfgChrBankCount = 1'b1
  } cfg_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } req_t;

  typedef struct packed {
    logic        handled;
    logic        from_ram;
    logic        ram_rd;
    logic        ram_wr;
    logic [21:0] mapped;
    logic [1:0]  mirror;
  } res_t;

  typedef struct packed {
    logic [4:0] control;
    logic [2:0] shift_count;
  } stat_t;

  // Fold a 13-bit window offset into the RAM depth; a smaller RAM is mirrored.
  function automatic logic [RamAw-1:0] ram_index(input logic [12:0] offs);
    logic [13:0] v;
    v = {1'b0, offs};
    for (int i = 0; i < 3; i++) begin
      if (v >= 14'(CartRamDepth)) v = v - 14'(CartRamDepth);
    end
    return v[RamAw-1:0];
  endfunction

endpackage

// File: src/serial_bank_switch_mapper_top.sv
// Serial bank switch mapper: stream request in, translated access out, APB config.
// One request is accepted every cycle unless the result stream stalls; the result
// is held in stage 1 for the synchronous RAM read, then in the output register.
// Bank registers update at the edge a request is accepted, so a request sees all
// earlier ones. A RAM write followed by a read of the same byte needs no bypass,
// since the write lands in the array before the following read is issued.
// The output register lets a new request in while a finished result is held.
`include "serial_bank_switch_mapper_top_macros.svh"

module serial_bank_switch_mapper_top
  import sbsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [21:0] mapped_address, [29:22] read_data,
                                      // [31:30] mirror_mode
  output logic [1:0]  m_axis_tuser,   // [0] handled, [1] from_cart_ram
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] prg_count_q, chr_count_q;
  logic       cfg_wr;

  req_t  req;
  res_t  res;
  stat_t stat;
  logic  s_acc;
  logic  s1_move;
  logic  s1_valid_q;
  res_t  s1_q;
  logic  out_valid_q;
  logic  out_handled_q, out_ram_q;
  logic [21:0] out_mapped_q;
  logic [7:0]  out_rdata_q, out_rdata_d;
  logic [1:0]  out_mirror_q;
  logic [7:0]  ram_rdata;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= PrgBankCountReset;
      chr_count_q <= ChrBankCountReset;
    end else if (cfg_wr) begin
      unique case (cfg_e'(paddr[2]))
        CfgPrgBankCount: prg_count_q <= pwdata[7:0];
        CfgChrBankCount: chr_count_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_e'(paddr[2]))
      CfgPrgBankCount: prdata = {24'd0, prg_count_q};
      CfgChrBankCount: prdata = {24'd0, chr_count_q};
      default:         prdata = '0;
    endcase
  end

  // Request decode and pipeline control
  assign req.op    = op_e'(s_axis_tuser);
  assign req.addr  = s_axis_tdata[15:0];
  assign req.wdata = s_axis_tdata[23:16];

  assign s1_move       = s1_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | s1_move;
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  sbsm_regs u_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (s_acc),
    .req_i            (req),
    .prg_bank_count_i (prg_count_q),
    .chr_bank_count_i (chr_count_q),
    .res_o            (res),
    .stat_o           (stat)
  );

  sbsm_ram u_ram (
    .clk_i   (clk_i),
    .rd_en_i (s_acc & res.ram_rd),
    .wr_en_i (s_acc & res.ram_wr),
    .offs_i  (req.addr[12:0]),
    .wdata_i (req.wdata),
    .rdata_o (ram_rdata)
  );

  // Stage 1: wait for the RAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_q <= res;
    end
  end

  // Output register
  assign out_rdata_d = s1_q.ram_rd ? ram_rdata : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_handled_q <= s1_q.handled;
      out_ram_q     <= s1_q.from_ram;
      out_mapped_q  <= s1_q.mapped;
      out_rdata_q   <= out_rdata_d;
      out_mirror_q  <= s1_q.mirror;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_mirror_q, out_rdata_q, out_mapped_q};
  assign m_axis_tuser  = {out_ram_q, out_handled_q};

  // Checks
  `SBSM_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_move, s1_valid_q && $stable(s1_q))
  `SBSM_ASSERT_NEXT(a_serial_reset, s_acc && req.op == OpCpuWrite && req.addr[15] && req.wdata[7], stat.control[3:2] == 2'b11 && stat.shift_count == 3'd0)
  `SBSM_ASSERT_NOW(a_count_range, 1'b1, stat.shift_count <= 3'd4)

endmodule

// File: src/sbsm_ram.sv
// Cartridge RAM: one synchronous port, registered read data.
module sbsm_ram
  import sbsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rd_en_i,
  input  logic        wr_en_i,
  input  logic [12:0] offs_i,
  input  logic [7:0]  wdata_i,
  output logic [7:0]  rdata_o
);

  logic [7:0]       mem [CartRamDepth];
  logic [7:0]       rdata_q;
  logic [RamAw-1:0] idx;

  assign idx = ram_index(offs_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[idx] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[idx];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sbsm_regs.sv
// Bank registers, serial load shift register and address translation.
module sbsm_regs
  import sbsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  req_t       req_i,
  input  logic [7:0] prg_bank_count_i,
  input  logic [7:0] chr_bank_count_i,
  output res_t       res_o,
  output stat_t      stat_o
);

  logic [4:0] control_q, control_d;
  logic [4:0] shift_q, shift_d;
  logic [2:0] count_q, count_d;
  logic [4:0] chr_low_q, chr_low_d;
  logic [4:0] chr_high_q, chr_high_d;
  logic [4:0] chr_whole_q, chr_whole_d;
  logic [2:0] prg_whole_q, prg_whole_d;
  logic [7:0] prg_low_q, prg_low_d;
  logic [7:0] prg_high_q, prg_high_d;

  res_t       res;
  logic [4:0] sh;
  logic [7:0] prg_bank;
  logic [4:0] chr_bank;
  logic       is_cpu;

  always_comb begin
    control_d   = control_q;
    shift_d     = shift_q;
    count_d     = count_q;
    chr_low_d   = chr_low_q;
    chr_high_d  = chr_high_q;
    chr_whole_d = chr_whole_q;
    prg_whole_d = prg_whole_q;
    prg_low_d   = prg_low_q;
    prg_high_d  = prg_high_q;
    res         = '0;
    sh          = {req_i.wdata[0], shift_q[4:1]};
    prg_bank    = req_i.addr[14] ? prg_high_q : prg_low_q;
    chr_bank    = req_i.addr[12] ? chr_high_q : chr_low_q;
    is_cpu      = (req_i.op == OpCpuRead) || (req_i.op == OpCpuWrite);

    if (is_cpu) begin
      if (req_i.addr[15:13] == 3'b011) begin
        res.handled  = 1'b1;
        res.from_ram = 1'b1;
        res.ram_rd   = (req_i.op == OpCpuRead);
        res.ram_wr   = (req_i.op == OpCpuWrite);
      end else if (req_i.addr[15]) begin
        if (req_i.op == OpCpuRead) begin
          res.handled = 1'b1;
          if (control_q[3]) begin
            res.mapped = {prg_bank, req_i.addr[13:0]};
          end else begin
            res.mapped = {4'd0, prg_whole_q, req_i.addr[14:0]};
          end
        end else if (req_i.wdata[7]) begin
          // Drop the partial load and force 16K mode with the last bank fixed
          shift_d   = '0;
          count_d   = '0;
          control_d = control_q | 5'h0C;
        end else if (count_q >= 3'd4) begin
          shift_d = '0;
          count_d = '0;
          unique case (tgt_e'(req_i.addr[14:13]))
            TgtControl: control_d = sh;
            TgtChrLow: begin
              if (control_q[4]) chr_low_d = sh;
              else              chr_whole_d = {sh[4:1], 1'b0};
            end
            TgtChrHigh: begin
              if (control_q[4]) chr_high_d = sh;
            end
            TgtPrg: begin
              unique case (prg_mode_e'(control_q[3:2])) inside
                PrgSwitch32A, PrgSwitch32B: prg_whole_d = sh[3:1];
                PrgFixFirst: begin
                  prg_low_d  = '0;
                  prg_high_d = {4'd0, sh[3:0]};
                end
                PrgFixLast: begin
                  prg_low_d  = {4'd0, sh[3:0]};
                  prg_high_d = prg_bank_count_i - 8'd1;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end else begin
          shift_d = sh;
          count_d = count_q + 3'd1;
        end
      end
    end else if (req_i.addr[15:13] == 3'b000) begin
      res.handled = 1'b1;
      if (chr_bank_count_i == 8'd0) begin
        res.mapped = {6'd0, req_i.addr};
      end else if (req_i.op == OpPpuRead) begin
        if (control_q[4]) begin
          res.mapped = {5'd0, chr_bank, req_i.addr[11:0]};
        end else begin
          res.mapped = 22'({chr_whole_q, 12'd0}) + 22'(req_i.addr[12:0]);
        end
      end
    end

    res.mirror = control_d[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q   <= ControlReset;
      shift_q     <= '0;
      count_q     <= '0;
      chr_low_q   <= '0;
      chr_high_q  <= '0;
      chr_whole_q <= '0;
      prg_whole_q <= '0;
      prg_low_q   <= '0;
      prg_high_q  <= PrgBankCountReset - 8'd1;
    end else if (req_valid_i) begin
      control_q   <= control_d;
      shift_q     <= shift_d;
      count_q     <= count_d;
      chr_low_q   <= chr_low_d;
      chr_high_q  <= chr_high_d;
      chr_whole_q <= chr_whole_d;
      prg_whole_q <= prg_whole_d;
      prg_low_q   <= prg_low_d;
      prg_high_q  <= prg_high_d;
    end
  end

  assign res_o              = res;
  assign stat_o.control     = control_q;
  assign stat_o.shift_count = count_q;

endmodule

// File: tb/sv/sbsm_access_checker.sv
// Checker for the serial bank switch mapper: predicts each access result and compares.
module sbsm_access_checker
  import sbsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [21:0] mapped_address, [29:22] read_data,
                                      // [31:30] mirror_mode
  input  logic [1:0]  m_axis_tuser,   // [0] handled, [1] from_cart_ram
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  localparam logic [15:0] RamWinLo   = 16'h6000;
  localparam logic [15:0] RamWinHi   = 16'h7FFF;
  localparam logic [15:0] RomWinLo   = 16'h8000;
  localparam logic [15:0] RomLowHi   = 16'hBFFF;
  localparam logic [15:0] ChrWinEnd  = 16'h2000;
  localparam logic [15:0] ChrLowHi   = 16'h0FFF;
  localparam logic [4:0]  ForceFixed = 5'h0C;

  typedef struct packed {
    logic        handled;
    logic        from_ram;
    logic [21:0] mapped;
    logic [7:0]  rdata;
    logic [1:0]  mirror;
  } access_result_t;

  // mirror of the mapper state
  logic [7:0] prg_count;
  logic [7:0] chr_count;
  logic [7:0] cart_ram [CartRamDepth];
  logic [4:0] control;
  logic [4:0] shift_reg;
  logic [2:0] shift_cnt;
  logic [4:0] chr_lo_4k;
  logic [4:0] chr_hi_4k;
  logic [4:0] chr_8k;
  logic [2:0] prg_32k;
  logic [7:0] prg_lo_16k;
  logic [7:0] prg_hi_16k;

  access_result_t expected_q[$];
  int             errors;

  function automatic access_result_t predict_access(input op_e op, input logic [15:0] addr,
                                                    input logic [7:0] wdata);
    access_result_t r;
    int unsigned    idx;
    int unsigned    m;
    logic [7:0]     bank;
    logic [4:0]     cbank;
    r = '0;
    m = 0;
    if (op == OpCpuRead || op == OpCpuWrite) begin
      if (addr >= RamWinLo && addr <= RamWinHi) begin
        r.handled  = 1'b1;
        r.from_ram = 1'b1;
        idx = int'(addr[12:0]) % CartRamDepth;
        if (op == OpCpuRead) r.rdata = cart_ram[idx];
        else cart_ram[idx] = wdata;
      end else if (addr >= RomWinLo) begin
        if (op == OpCpuRead) begin
          r.handled = 1'b1;
          if (control[3]) begin
            bank = (addr <= RomLowHi) ? prg_lo_16k : prg_hi_16k;
            m = int'(bank) * 32'h4000 + int'(addr[13:0]);
          end else begin
            m = int'(prg_32k) * 32'h8000 + int'(addr[14:0]);
          end
        end else if (wdata[7]) begin
          shift_reg = '0;
          shift_cnt = '0;
          control   = control | ForceFixed;
        end else begin
          shift_reg = {wdata[0], shift_reg[4:1]};
          shift_cnt = shift_cnt + 3'd1;
          if (shift_cnt >= 3'd5) begin
            case (tgt_e'(addr[14:13]))
              TgtControl: control = shift_reg;
              TgtChrLow: begin
                if (control[4]) chr_lo_4k = shift_reg;
                else chr_8k = shift_reg & 5'h1E;
              end
              TgtChrHigh: begin
                if (control[4]) chr_hi_4k = shift_reg;
              end
              default: begin
                // PRG load follows the mode in force at this write
                case (prg_mode_e'(control[3:2]))
                  PrgSwitch32A, PrgSwitch32B: prg_32k = shift_reg[3:1];
                  PrgFixFirst: begin
                    prg_lo_16k = '0;
                    prg_hi_16k = {4'b0, shift_reg[3:0]};
                  end
                  default: begin
                    prg_lo_16k = {4'b0, shift_reg[3:0]};
                    prg_hi_16k = prg_count - 8'd1;
                  end
                endcase
              end
            endcase
            shift_reg = '0;
            shift_cnt = '0;
          end
        end
      end
    end else if (addr < ChrWinEnd) begin
      r.handled = 1'b1;
      if (chr_count == 8'd0) begin
        m = int'(addr);
      end else if (op == OpPpuRead) begin
        if (control[4]) begin
          cbank = (addr <= ChrLowHi) ? chr_lo_4k : chr_hi_4k;
          m = int'(cbank) * 32'h1000 + int'(addr[11:0]);
        end else begin
          m = int'(chr_8k) * 32'h1000 + int'(addr[12:0]);
        end
      end
    end
    r.mapped = m[21:0];
    r.mirror = control[1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t got;
    access_result_t exp;
    logic [31:0]    cfg_exp;
    if (!rst_ni) begin
      prg_count  = PrgBankCountReset;
      chr_count  = ChrBankCountReset;
      control    = ControlReset;
      shift_reg  = '0;
      shift_cnt  = '0;
      chr_lo_4k  = '0;
      chr_hi_4k  = '0;
      chr_8k     = '0;
      prg_32k    = '0;
      prg_lo_16k = '0;
      prg_hi_16k = PrgBankCountReset - 8'd1;
      expected_q.delete();
      errors = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (cfg_e'(paddr[2]) == CfgPrgBankCount) prg_count = pwdata[7:0];
          else chr_count = pwdata[7:0];
        end else begin
          cfg_exp = {24'b0, (cfg_e'(paddr[2]) == CfgPrgBankCount) ? prg_count : chr_count};
          if (prdata !== cfg_exp) begin
            errors++;
            if (errors <= 10)
              $display("config readback mismatch at paddr %0d: exp %h got %h",
                       paddr, cfg_exp, prdata);
          end
        end
      end
      // compare the oldest expectation before taking the new request
      if (m_axis_tvalid && m_axis_tready) begin
        got.handled  = m_axis_tuser[0];
        got.from_ram = m_axis_tuser[1];
        got.mapped   = m_axis_tdata[21:0];
        got.rdata    = m_axis_tdata[29:22];
        got.mirror   = m_axis_tdata[31:30];
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: handled=%0d ram=%0d addr=%h data=%h mirror=%0d",
                     got.handled, got.from_ram, got.mapped, got.rdata, got.mirror);
        end else begin
          exp = expected_q.pop_front();
          if (got !== exp) begin
            errors++;
            if (errors <= 10)
              $display({"result mismatch: exp handled=%0d ram=%0d addr=%h data=%h mirror=%0d",
                        " | got handled=%0d ram=%0d addr=%h data=%h mirror=%0d"},
                       exp.handled, exp.from_ram, exp.mapped, exp.rdata, exp.mirror,
                       got.handled, got.from_ram, got.mapped, got.rdata, got.mirror);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(predict_access(op_e'(s_axis_tuser), s_axis_tdata[15:0],
                                            s_axis_tdata[23:16]));
      mismatch_count_o <= errors;
      pending_count_o  <= expected_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the serial bank switch mapper: stimulus, config phases and verdict.
module tb_top
  import sbsm_pkg::*;
();

  localparam int          NumPhases    = 8;
  localparam int          PhaseItems   = 230;
  localparam int          SqueezePhase = 2;
  localparam int          SqueezeLen   = 300;
  localparam int          CycleLimit   = 600000;
  localparam logic [15:0] RamWinLo     = 16'h6000;
  localparam logic [15:0] RamWinHi     = 16'h7FFF;
  localparam logic [15:0] RomWinLo     = 16'h8000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [15:0] address, [23:16] write_data
  logic [1:0]  s_axis_tuser;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [21:0] mapped_address, [29:22] read_data, [31:30] mirror_mode
  logic [1:0]  m_axis_tuser;   // [0] handled, [1] from_cart_ram
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int pending_count;
  int cycle_count;
  int sender_idle_pct;
  int receiver_idle_pct;
  bit squeeze_req;

  bit ram_mark [CartRamDepth];
  int ram_written_q[$];

  int prg_plan  [NumPhases] = '{4, 1, 255, 2, 16, 255, 1, 128};
  int chr_plan  [NumPhases] = '{0, 255, 1, 0, 8, 255, 3, 0};
  int idle_plan [NumPhases] = '{30, 0, 40, 20, 0, 30, 50, 25};

  serial_bank_switch_mapper_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sbsm_access_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatch_count_o(mismatch_count),
    .pending_count_o(pending_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left   = SqueezeLen;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        m_axis_tready <= 1'b0;
        gap_left--;
      end else begin
        m_axis_tready <= 1'b1;
        gap_left = pick_gap(receiver_idle_pct);
      end
    end
  end

  task automatic cfg_write(input cfg_e idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'b0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read it back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_access(input op_e op, input logic [15:0] addr, input logic [7:0] wdata);
    int gap;
    int idx;
    if (op == OpCpuWrite && addr >= RamWinLo && addr <= RamWinHi) begin
      idx = int'(addr[12:0]) % CartRamDepth;
      if (!ram_mark[idx]) begin
        ram_mark[idx] = 1'b1;
        ram_written_q.push_back(idx);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wdata, addr};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    gap = pick_gap(sender_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // five serial writes, LSB first; the last address picks the target register
  task automatic serial_load(input logic [15:0] addr, input logic [4:0] value);
    logic [15:0] a;
    for (int i = 0; i < 5; i++) begin
      a = (i == 4) ? addr : (RomWinLo | 16'(15'($urandom)));
      send_access(OpCpuWrite, a, {1'b0, 6'($urandom), value[i]});
    end
  endtask

  task automatic random_accesses(input int count);
    int          sent;
    int          pick;
    int          idx;
    op_e         op;
    logic [15:0] a;
    logic [7:0]  d;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      d    = 8'($urandom);
      if (pick < 30) begin
        if ($urandom_range(0, 2) == 0) begin
          send_access(OpCpuWrite, RomWinLo | 16'(15'($urandom)), 8'h80 | d);
          sent++;
        end
        serial_load(RomWinLo | 16'(15'($urandom)), 5'($urandom));
        sent += 5;
      end else begin
        if (pick < 50) begin
          op = OpCpuRead;
          a  = RomWinLo | 16'(15'($urandom));
        end else if (pick < 65) begin
          op = ($urandom_range(0, 1) == 0) ? OpPpuRead : OpPpuWrite;
          a  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : {3'b000, 13'($urandom)};
        end else if (pick < 80 || ram_written_q.size() == 0) begin
          op = OpCpuWrite;
          a  = RamWinLo | 16'(13'($urandom));
        end else if (pick < 90) begin
          op  = OpCpuRead;
          idx = ram_written_q[$urandom_range(0, ram_written_q.size() - 1)];
          a   = RamWinLo | 16'(idx);
        end else begin
          op = op_e'($urandom_range(0, 3));
          a  = 16'($urandom);
          // keep reads away from RAM bytes never written
          if (op == OpCpuRead && a >= RamWinLo && a <= RamWinHi &&
              !ram_mark[int'(a[12:0]) % CartRamDepth])
            op = OpCpuWrite;
        end
        send_access(op, a, d);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    s_axis_tuser      = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cycle_count       = 0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    squeeze_req       = 1'b0;
    prg_plan[NumPhases-1] = $urandom_range(1, 255);
    chr_plan[NumPhases-1] = $urandom_range(0, 255);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      cfg_write(CfgPrgBankCount, 8'(prg_plan[ph]));
      cfg_write(CfgChrBankCount, 8'(chr_plan[ph]));
      sender_idle_pct   = idle_plan[ph];
      receiver_idle_pct = idle_plan[ph];
      if (ph == 0) begin
        // fixed-last PRG banks from reset; the high bank still follows the reset count
        send_access(OpCpuRead, 16'h8000, 8'h00);
        send_access(OpCpuRead, 16'hFFFF, 8'h00);
        // unclaimed CPU window
        send_access(OpCpuRead, 16'h0000, 8'h00);
        send_access(OpCpuWrite, 16'h5FFF, 8'hFF);
        // cartridge RAM at both ends of its window
        send_access(OpCpuWrite, RamWinLo, 8'hA5);
        send_access(OpCpuWrite, RamWinHi, 8'h5A);
        send_access(OpCpuRead, RamWinLo, 8'h00);
        send_access(OpCpuRead, RamWinHi, 8'h00);
        // CHR RAM pass-through, and PPU accesses outside pattern space
        send_access(OpPpuRead, 16'h0000, 8'h00);
        send_access(OpPpuWrite, 16'h1FFF, 8'hFF);
        send_access(OpPpuRead, 16'h2000, 8'h00);
        send_access(OpPpuWrite, 16'hFFFF, 8'h00);
        // shift reset, then a PRG load in fixed-last mode picks up the new bank count
        send_access(OpCpuWrite, RomWinLo, 8'h80);
        serial_load(16'hE000, 5'h0F);
        send_access(OpCpuRead, 16'hC000, 8'h00);
        send_access(OpCpuWrite, 16'h9234, 8'hFF);
        // control: 4K CHR, 32K PRG, vertical mirroring
        serial_load(RomWinLo, 5'h12);
      end
      if (ph == SqueezePhase) squeeze_req = 1'b1;
      random_accesses(PhaseItems);
      s_axis_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clk_i);
      repeat (4) @(negedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/sbsm_pkg.sv
src/sbsm_ram.sv
src/sbsm_regs.sv
src/serial_bank_switch_mapper_top.sv
tb/sv/sbsm_access_checker.sv
tb/sv/tb_top.sv
